// File: design/matrix_multiply_engine_core_macros.svh
// Assertion macros for the matrix multiply engine.
// Used by the top level only; no other dependencies.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH
// Checks a property on every rising edge of clk outside reset.
`define MME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks a property on every rising edge of clk, reset included.
`define MME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: design/mme_pkg.sv
// Package of the matrix multiply engine: codes, widths, state and cell control types.
// No dependencies.
`default_nettype none
package mme_pkg;
  localparam int DIM_W = 4;
  localparam int IDX_W = 3;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W = 35;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_BLOAD, ST_MAC, ST_DRAIN} mme_state_t;

  typedef struct packed {
    logic               mac_v;
    logic               first;
    logic [IDX_W-1:0]   t;
    logic               shift;
    logic               bw_en;
    logic [IDX_W-1:0]   bw_row;
    logic [ELEM_W-1:0]  bw_data;
  } cell_ctl_t;
endpackage
`default_nettype wire

// File: design/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: command channel, element stores, sequencer.
// Depends on mme_pkg, mme_cell and matrix_multiply_engine_core_macros.svh.
`default_nettype none
// Usage.
// A command word is taken at a rising edge where start is high and busy is low.
// Op load A or load B writes one element at its row-major index; an index at or
// beyond the element count under the current dimensions is dropped.
// Op compute emits every element of C in row-major order, one word per cycle on
// out_valid within a row of C, with last set on the final one. The receiver cannot
// stall, so each result word is present for exactly one cycle.
// Sequence of a compute of M x N times N x K: B is copied from its store into the
// first K column cells, then each row of C has a multiply and accumulate phase (one
// A element broadcast per cycle, read from the A store port) and a drain phase in
// which the accumulators shift toward cell zero and leave the block. Busy stays high
// throughout. Configuration writes set the three dimensions; 0 acts as 1 and values
// above MAX_DIM act as MAX_DIM. They must only be written while busy is low; the
// block itself does not enforce this. Reset (synchronous, active low) sets all
// dimensions to 8 and returns to idle; the element stores are not cleared and must
// be written before they are read.
module matrix_multiply_engine_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [5:0]                        in_elem_index,
  input  logic signed [mme_pkg::ELEM_W-1:0] in_elem_value,
  output logic                              out_valid,
  output logic [mme_pkg::IDX_W-1:0]         out_row_out,
  output logic [mme_pkg::IDX_W-1:0]         out_col_out,
  output logic signed [mme_pkg::SUM_W-1:0]  out_product_sum,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_wdata
);
  import mme_pkg::*;
  `include "matrix_multiply_engine_core_macros.svh"

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  // Dimension registers keep the bits written; the clamped copies drive the logic.
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] m_eff, n_eff, k_eff;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  assign m_eff = clamp_dim(rows_a_r);
  assign n_eff = clamp_dim(inner_dim_r);
  assign k_eff = clamp_dim(cols_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_wdata;
        REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        REG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  mme_state_t       state_r, state_nxt;
  logic [AW-1:0]    a_addr_r, a_addr_nxt;
  logic [AW-1:0]    b_addr_r, b_addr_nxt;
  logic [DIM_W-1:0] mt_r, mt_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] bt_r, bt_nxt;
  logic [IDX_W-1:0] bj_r, bj_nxt;

  logic accept;
  logic a_issue, a_first, b_issue, drain_shift;
  logic wr_a, wr_b;
  logic [7:0] a_count, b_count;

  assign accept  = start && !busy;
  assign a_count = {4'b0, m_eff} * {4'b0, n_eff};
  assign b_count = {4'b0, n_eff} * {4'b0, k_eff};
  assign wr_a    = accept && (in_op == OP_LOAD_A) && ({2'b0, in_elem_index} < a_count);
  assign wr_b    = accept && (in_op == OP_LOAD_B) && ({2'b0, in_elem_index} < b_count);

  always_comb begin
    state_nxt   = state_r;
    a_addr_nxt  = a_addr_r;
    b_addr_nxt  = b_addr_r;
    mt_nxt      = mt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    bt_nxt      = bt_r;
    bj_nxt      = bj_r;
    a_issue     = 1'b0;
    a_first     = 1'b0;
    b_issue     = 1'b0;
    drain_shift = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_COMPUTE)) begin
          state_nxt  = ST_BLOAD;
          b_addr_nxt = '0;
          bt_nxt     = '0;
          bj_nxt     = '0;
        end
      end
      ST_BLOAD: begin
        b_issue    = 1'b1;
        b_addr_nxt = b_addr_r + AW'(1);
        if ({1'b0, bj_r} == k_eff - DIM_W'(1)) begin
          bj_nxt = '0;
          bt_nxt = bt_r + IDX_W'(1);
          if ({1'b0, bt_r} == n_eff - DIM_W'(1)) begin
            state_nxt  = ST_MAC;
            mt_nxt     = '0;
            row_nxt    = '0;
            a_addr_nxt = '0;
          end
        end else begin
          bj_nxt = bj_r + IDX_W'(1);
        end
      end
      ST_MAC: begin
        // Issue N reads of the current row of A, then let the two-stage MAC settle.
        mt_nxt = mt_r + DIM_W'(1);
        if (mt_r < n_eff) begin
          a_issue    = 1'b1;
          a_first    = (mt_r == '0);
          a_addr_nxt = a_addr_r + AW'(1);
        end
        if (mt_r == n_eff + DIM_W'(1)) begin
          state_nxt = ST_DRAIN;
          col_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        drain_shift = 1'b1;
        col_nxt     = col_r + IDX_W'(1);
        if ({1'b0, col_r} == k_eff - DIM_W'(1)) begin
          if ({1'b0, row_r} == m_eff - DIM_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            mt_nxt    = '0;
            row_nxt   = row_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    mt_r     <= mt_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    bt_r     <= bt_nxt;
    bj_r     <= bj_nxt;
  end

  // Element stores, one write and one registered read port each.
  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_r, b_rd_r;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[in_elem_index[AW-1:0]] <= in_elem_value;
    end
    a_rd_r <= a_mem[a_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[in_elem_index[AW-1:0]] <= in_elem_value;
    end
    b_rd_r <= b_mem[b_addr_r];
  end

  // Tags registered in step with the store read data, so that they line up with it.
  logic             mac_v_r, bw_v_r;
  logic             first_r;
  logic [IDX_W-1:0] t_r, bw_t_r, bw_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v_r <= 1'b0;
      bw_v_r  <= 1'b0;
    end else begin
      mac_v_r <= a_issue;
      bw_v_r  <= b_issue;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= a_first;
    t_r     <= mt_r[IDX_W-1:0];
    bw_t_r  <= bt_r;
    bw_j_r  <= bj_r;
  end

  cell_ctl_t ctl;
  always_comb begin
    ctl.mac_v   = mac_v_r;
    ctl.first   = first_r;
    ctl.t       = t_r;
    ctl.shift   = drain_shift;
    ctl.bw_en   = bw_v_r;
    ctl.bw_row  = bw_t_r;
    ctl.bw_data = b_rd_r;
  end

  // Row of column cells; during drain each cell takes its right neighbor's sum.
  logic signed [SUM_W-1:0] acc_w [MAX_DIM+1];
  assign acc_w[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mme_cell #(.MAX_DIM(MAX_DIM)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .b_sel   (32'(bw_j_r) == j),
      .a_val   (a_rd_r),
      .acc_in  (acc_w[j+1]),
      .acc_out (acc_w[j])
    );
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DRAIN);
  assign out_row_out     = row_r;
  assign out_col_out     = col_r;
  assign out_product_sum = acc_w[0];
  assign out_last        = out_valid && ({1'b0, row_r} == m_eff - DIM_W'(1))
                           && ({1'b0, col_r} == k_eff - DIM_W'(1));

  // A result only appears while a compute is running.
  `MME_ASSERT(a_out_busy, out_valid |-> busy, "result word while idle")
  // The final word of C ends the compute on the next cycle.
  `MME_ASSERT(a_last_idle, out_last |=> !busy, "block still busy after last word")
  // An accepted compute raises busy on the next cycle.
  `MME_ASSERT(a_cmp_busy, (accept && in_op == OP_COMPUTE) |=> busy, "compute not started")
  // The MAC pipeline never runs at the same time as the drain shift.
  `MME_ASSERT(a_mac_drain, !(mac_v_r && drain_shift), "MAC overlaps drain")
endmodule
`default_nettype wire

// File: design/mme_cell.sv
// One column cell: holds a column of B, a multiplier and an accumulator.
// Depends on mme_pkg.
`default_nettype none
module mme_cell #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::cell_ctl_t                ctl,
  input  logic                              b_sel,
  input  logic signed [mme_pkg::ELEM_W-1:0] a_val,
  input  logic signed [mme_pkg::SUM_W-1:0]  acc_in,
  output logic signed [mme_pkg::SUM_W-1:0]  acc_out
);
  import mme_pkg::*;

  localparam int TW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [ELEM_W-1:0] b_col_r [MAX_DIM];
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic                     prod_first_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (ctl.bw_en && b_sel) begin
      b_col_r[ctl.bw_row[TW-1:0]] <= ctl.bw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.mac_v;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= a_val * b_col_r[ctl.t[TW-1:0]];
    prod_first_r <= ctl.first;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (prod_v_r) begin
      acc_nxt = (prod_first_r ? '0 : acc_r) + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;
endmodule
`default_nettype wire

// File: verif/tb_matrix_multiply_engine_core.sv
// Self-checking testbench for the matrix multiply engine top level.
// Depends on mme_pkg and matrix_multiply_engine_core from the design folder.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the dimension registers and of both element
// stores, and the queue of C elements that the block is expected to emit.
class gemm_scoreboard;
  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [34:0] sum;
    logic        last;
  } c_elem_t;

  logic [3:0] dim_reg [3];
  int a_mem [64];
  int b_mem [64];
  c_elem_t c_pending [$];
  int errors;
  int checked;

  function new();
    foreach (dim_reg[i]) dim_reg[i] = 4'd8;
    foreach (a_mem[i]) a_mem[i] = 0;
    foreach (b_mem[i]) b_mem[i] = 0;
    errors = 0;
    checked = 0;
  endfunction

  function int clamp_dim(logic [3:0] r);
    if (r == 0) return 1;
    if (r > 8) return 8;
    return int'(r);
  endfunction

  function void write_dim(logic [1:0] index, logic [3:0] value);
    if (index <= mme_pkg::REG_COLS_B) dim_reg[index] = value;
  endfunction

  // Notes one accepted command word and queues the C elements it causes.
  function void note_word(logic [1:0] op, logic [5:0] idx, logic signed [15:0] val);
    int m, n, k;
    longint acc;
    c_elem_t e;
    m = clamp_dim(dim_reg[mme_pkg::REG_ROWS_A]);
    n = clamp_dim(dim_reg[mme_pkg::REG_INNER_DIM]);
    k = clamp_dim(dim_reg[mme_pkg::REG_COLS_B]);
    if (op == mme_pkg::OP_LOAD_A) begin
      if (int'(idx) < m * n) a_mem[idx] = int'(val);
    end else if (op == mme_pkg::OP_LOAD_B) begin
      if (int'(idx) < n * k) b_mem[idx] = int'(val);
    end else if (op == mme_pkg::OP_COMPUTE) begin
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < k; j++) begin
          acc = 0;
          for (int t = 0; t < n; t++) acc += longint'(a_mem[i*n+t]) * b_mem[t*k+j];
          e.row = 3'(i);
          e.col = 3'(j);
          e.sum = acc[34:0];
          e.last = (i == m - 1) && (j == k - 1);
          c_pending.push_back(e);
        end
      end
    end
  endfunction

  // Compares one emitted C element with the oldest expected one.
  function void check_word(logic [2:0] row, logic [2:0] col, logic [34:0] sum, logic last);
    c_elem_t e;
    if (c_pending.size() == 0) begin
      $display("%0t: unexpected result row %0d col %0d sum %h", $time, row, col, sum);
      errors++;
      return;
    end
    e = c_pending.pop_front();
    checked++;
    if (row !== e.row) begin
      $display("%0t: row_out expected %0d actual %0d", $time, e.row, row);
      errors++;
    end
    if (col !== e.col) begin
      $display("%0t: col_out expected %0d actual %0d", $time, e.col, col);
      errors++;
    end
    if (sum !== e.sum) begin
      $display("%0t: product_sum expected %h actual %h", $time, e.sum, sum);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_matrix_multiply_engine_core;
  import mme_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_op;
  logic [5:0] in_elem_index;
  logic signed [ELEM_W-1:0] in_elem_value;
  logic out_valid;
  logic [IDX_W-1:0] out_row_out;
  logic [IDX_W-1:0] out_col_out;
  logic signed [SUM_W-1:0] out_product_sum;
  logic out_last;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  gemm_scoreboard sb;
  int idle_cycles;
  int n_loads;
  int n_computes;
  int n_cfg;

  matrix_multiply_engine_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_elem_index(in_elem_index), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_row_out(out_row_out), .out_col_out(out_col_out),
    .out_product_sum(out_product_sum), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: the block cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_row_out, out_col_out, out_product_sum, out_last);
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Mostly back-to-back words, some short pauses, and now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one command word after a random gap and returns at the edge where it
  // is taken. The caller must drive start again in that same time step.
  task automatic send_word(logic [1:0] op, logic [5:0] idx, logic [15:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_elem_index <= idx;
    in_elem_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(op, idx, val);
    if (op == OP_COMPUTE) n_computes++;
    else if (op != 2'd3) n_loads++;
  endtask

  // Lowers start and waits until the block is idle and every C element is in.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.c_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only once the block has drained.
  task automatic write_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
    drain_block();
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_wdata <= rows;
    @(posedge clk);
    sb.write_dim(REG_ROWS_A, rows);
    cfg_index <= REG_INNER_DIM;
    cfg_wdata <= inner;
    @(posedge clk);
    sb.write_dim(REG_INNER_DIM, inner);
    cfg_index <= REG_COLS_B;
    cfg_wdata <= cols;
    @(posedge clk);
    sb.write_dim(REG_COLS_B, cols);
    cfg_we <= 1'b0;
    n_cfg += 3;
  endtask

  function logic [3:0] pick_dim();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(15, 9));
    if (r < 7) return 4'($urandom_range(3, 1));
    return 4'($urandom_range(8, 4));
  endfunction

  function logic [15:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  initial begin
    logic [1:0] op;
    int m, n, k, items, burst;
    sb = new();
    n_loads = 0;
    n_computes = 0;
    n_cfg = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOAD_A;
    in_elem_index = '0;
    in_elem_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ROWS_A;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Under the reset dimensions every store entry is addressable, so both
    // stores are filled first; no compute can then read an unwritten element.
    for (int i = 0; i < 64; i++) send_word(OP_LOAD_A, 6'(i), 16'($urandom));
    for (int i = 0; i < 64; i++) send_word(OP_LOAD_B, 6'(i), 16'($urandom));

    // Directed part: full-scale operands, dropped loads, the unused opcode.
    send_word(OP_COMPUTE, 6'($urandom), 16'($urandom));
    write_dims(4'd1, 4'd1, 4'd1);
    send_word(OP_LOAD_A, 6'd0, 16'h8000);
    send_word(OP_LOAD_B, 6'd0, 16'h8000);
    send_word(OP_LOAD_A, 6'd1, 16'h1234);
    send_word(OP_LOAD_B, 6'd63, 16'h4321);
    send_word(OP_COMPUTE, 6'd63, 16'hffff);
    send_word(2'd3, 6'd0, 16'h7fff);
    send_word(OP_COMPUTE, 6'd0, 16'h0000);
    write_dims(4'd8, 4'd8, 4'd8);
    for (int i = 0; i < 8; i++) send_word(OP_LOAD_A, 6'(i), 16'h8000);
    for (int i = 0; i < 8; i++) send_word(OP_LOAD_B, 6'(i * 8), 16'h8000);
    send_word(OP_COMPUTE, 6'd0, 16'h0);
    // Zero reads as one and large values read as eight.
    write_dims(4'd0, 4'd15, 4'd0);
    send_word(OP_COMPUTE, 6'd0, 16'h0);
    write_dims(4'd15, 4'd0, 4'd9);
    send_word(OP_COMPUTE, 6'd0, 16'h0);

    // Random part: phases of new dimensions, mostly loads inside the matrices
    // followed by a compute, mixed with dropped loads and the unused opcode.
    items = 0;
    while (items < 270) begin
      write_dims(pick_dim(), pick_dim(), pick_dim());
      m = sb.clamp_dim(sb.dim_reg[REG_ROWS_A]);
      n = sb.clamp_dim(sb.dim_reg[REG_INNER_DIM]);
      k = sb.clamp_dim(sb.dim_reg[REG_COLS_B]);
      for (int p = 0; p < 3; p++) begin
        burst = $urandom_range(10, 2);
        for (int q = 0; q < burst; q++) begin
          op = 2'($urandom_range(1));
          if ($urandom_range(9) == 0) begin
            send_word($urandom_range(3, 2) == 3 ? 2'd3 : op, 6'($urandom), 16'($urandom));
          end else if (op == OP_LOAD_A) begin
            send_word(OP_LOAD_A, 6'($urandom_range(m * n - 1)), pick_value());
          end else begin
            send_word(OP_LOAD_B, 6'($urandom_range(n * k - 1)), pick_value());
          end
          items++;
        end
        send_word(OP_COMPUTE, 6'($urandom), 16'($urandom));
        items++;
      end
    end

    drain_block();
    repeat (20) @(posedge clk);
    $display("ran %0d loads, %0d computes and %0d register writes", n_loads, n_computes, n_cfg);
    $display("checked %0d elements of C", sb.checked);
    if (sb.errors == 0 && sb.c_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/mme_pkg.sv
design/mme_cell.sv
design/matrix_multiply_engine_core.sv
verif/tb_matrix_multiply_engine_core.sv
